[hdl/aaf_pkg.sv]
// aaf_pkg: shared types and constants of the accumulator alu with flags
// opcodes, address register codes, payload structs, controller command/status
// no dependencies
package aaf_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = 6;
  localparam int unsigned PC_W      = 12;
  localparam int unsigned CMD_W     = 4;
  localparam int unsigned DIV_CNT_W = $clog2(DATA_W);
  // carry limit is 2**CARRY_BIT
  localparam int unsigned CARRY_BIT = 16;

  typedef enum logic [CMD_W-1:0] {
    OP_LDA = 4'd0,
    OP_STA = 4'd1,
    OP_ADD = 4'd2,
    OP_SUB = 4'd3,
    OP_MUL = 4'd4,
    OP_DIV = 4'd5,
    OP_XOR = 4'd6,
    OP_OR  = 4'd7,
    OP_AND = 4'd8,
    OP_INC = 4'd9,
    OP_CMA = 4'd10,
    OP_CLA = 4'd11,
    OP_HLT = 4'd12,
    OP_LDW = 4'd13
  } op_e;

  localparam logic [PC_W-1:0] AR_INC = 12'h020;
  localparam logic [PC_W-1:0] AR_CMA = 12'h200;
  localparam logic [PC_W-1:0] AR_CLA = 12'h800;
  localparam logic [PC_W-1:0] AR_HLT = 12'h001;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] write_data;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] acc_value;
    logic                     zero_flag;
    logic                     sign_flag;
    logic                     carry_flag;
    logic                     parity_flag;
    logic                     syntax_error;
    logic [PC_W-1:0]          address_reg;
    logic [PC_W-1:0]          program_counter;
  } out_t;

  typedef struct packed {
    logic parity;
    logic carry;
    logic sign;
    logic zero;
  } flags_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic exec;
    logic div_start;
    logic div_take;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_needed;
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

[hdl/aaf_ram.sv]
// aaf_ram: generic single-port ram with registered read
// no dependencies
module aaf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/aaf_div.sv]
// aaf_div: iterative signed divider, one quotient bit per cycle
// depends on aaf_pkg
module aaf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [aaf_pkg::DATA_W-1:0]    dividend_i,
  input  logic [aaf_pkg::DATA_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [aaf_pkg::DATA_W-1:0]    quot_o
);

  localparam int unsigned W = aaf_pkg::DATA_W;

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [aaf_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [W-1:0]                    q_q, q_d;
  logic [W-1:0]                    r_q, r_d;
  logic [W-1:0]                    d_q, d_d;
  logic                            neg_q, neg_d;
  logic [W:0]                      r_sh;
  logic [W:0]                      diff;

  assign r_sh = {r_q, q_q[W-1]};
  assign diff = r_sh - {1'b0, d_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    q_d    = q_q;
    r_d    = r_q;
    d_d    = d_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      r_d    = '0;
      q_d    = dividend_i[W-1] ? (~dividend_i + 1'b1) : dividend_i;
      d_d    = divisor_i[W-1] ? (~divisor_i + 1'b1) : divisor_i;
      neg_d  = dividend_i[W-1] ^ divisor_i[W-1];
    end else if (busy_q) begin
      // restoring step: shift in next dividend bit, subtract when it fits
      if (!diff[W]) begin
        r_d = diff[W-1:0];
      end else begin
        r_d = r_sh[W-1:0];
      end
      q_d   = {q_q[W-2:0], ~diff[W]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == aaf_pkg::DIV_CNT_W'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    r_q   <= r_d;
    d_q   <= d_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~q_q + 1'b1) : q_q;

endmodule

[hdl/aaf_dp.sv]
// aaf_dp: datapath with accumulator, flags, pc/ar, data memory and output word
// depends on aaf_pkg, aaf_ram, aaf_div
module aaf_dp #(
  parameter int unsigned MEM_WORDS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  aaf_pkg::ctrl_cmd_t         cmd_i,
  output aaf_pkg::ctrl_sts_t         sts_o,
  input  aaf_pkg::in_t               in_data_i,
  input  logic                       cfg_we_i,
  input  logic [aaf_pkg::PC_W-1:0]   cfg_data_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output aaf_pkg::out_t              out_data_o
);

  localparam int unsigned IDX_W = $clog2(MEM_WORDS);
  localparam int unsigned W     = aaf_pkg::DATA_W;
  localparam logic [IDX_W:0] MemLim = (IDX_W + 1)'(MEM_WORDS);

  logic [aaf_pkg::CMD_W-1:0]  cmd_q;
  logic [aaf_pkg::ADDR_W-1:0] addr_q;
  logic [IDX_W-1:0]           idx_q, idx_in;
  logic [W-1:0]               wdata_q;
  logic [W-1:0]               pend_q, pend_d;
  logic                       err_q, err_d;
  logic [W-1:0]               acc_q, acc_nx;
  aaf_pkg::flags_t            flags_q, flags_nx;
  logic [aaf_pkg::PC_W-1:0]   pc_q, pc_nx, ar_q, ar_nx;
  logic [IDX_W-1:0]           clr_cnt_q;
  logic                       out_valid_q;
  aaf_pkg::out_t              out_q, out_nx;
  logic [IDX_W:0]             rem;

  logic                       ram_we;
  logic [IDX_W-1:0]           ram_addr;
  logic [W-1:0]               ram_wdata, operand;
  logic [W-1:0]               mul_res;
  logic                       div_done;
  logic [W-1:0]               div_quot;
  logic                       carry;
  logic [W-1:0]               pend_red;

  // word index modulo memory depth, restoring remainder over the address bits
  always_comb begin
    rem = '0;
    for (int i = aaf_pkg::ADDR_W - 1; i >= 0; i--) begin
      rem = {rem[IDX_W-1:0], in_data_i.addr[i]};
      if (rem >= MemLim) begin
        rem = rem - MemLim;
      end
    end
    idx_in = rem[IDX_W-1:0];
  end

  // memory port: clearing pass, read at accept, write at execute
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx_q;
    ram_wdata = acc_q;
    if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_q;
      ram_wdata = '0;
    end else if (cmd_i.accept) begin
      ram_addr = idx_in;
    end else if (cmd_i.exec) begin
      if (cmd_q == aaf_pkg::OP_STA) begin
        ram_we = 1'b1;
      end else if (cmd_q == aaf_pkg::OP_LDW) begin
        ram_we    = 1'b1;
        ram_wdata = wdata_q;
      end
    end
  end

  aaf_ram #(
    .WIDTH(W),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(operand)
  );

  aaf_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(acc_q),
    .divisor_i (operand),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign mul_res = acc_q * operand;

  // execute: new accumulator before flag update
  always_comb begin
    pend_d = acc_q;
    err_d  = 1'b0;
    case (aaf_pkg::op_e'(cmd_q))
      aaf_pkg::OP_LDA: pend_d = operand;
      aaf_pkg::OP_STA: pend_d = acc_q;
      aaf_pkg::OP_ADD: pend_d = acc_q + operand;
      aaf_pkg::OP_SUB: pend_d = acc_q - operand;
      aaf_pkg::OP_MUL: pend_d = mul_res;
      aaf_pkg::OP_DIV: err_d  = (operand == '0);
      aaf_pkg::OP_XOR: pend_d = acc_q ^ operand;
      aaf_pkg::OP_OR:  pend_d = acc_q | operand;
      aaf_pkg::OP_AND: pend_d = acc_q & operand;
      aaf_pkg::OP_INC: pend_d = acc_q + 1'b1;
      aaf_pkg::OP_CMA: pend_d = ~acc_q;
      aaf_pkg::OP_CLA: pend_d = '0;
      aaf_pkg::OP_HLT: pend_d = acc_q;
      aaf_pkg::OP_LDW: pend_d = acc_q;
      default:         err_d  = 1'b1;
    endcase
  end

  // commit: flags, carry reduction, pc and ar
  assign carry    = !pend_q[W-1] && (pend_q[W-2:aaf_pkg::CARRY_BIT] != '0);
  assign pend_red = carry ? {{(W - aaf_pkg::CARRY_BIT){1'b0}},
                             pend_q[aaf_pkg::CARRY_BIT-1:0]} : pend_q;

  always_comb begin
    acc_nx   = acc_q;
    flags_nx = flags_q;
    pc_nx    = pc_q;
    ar_nx    = ar_q;
    if (cmd_q != aaf_pkg::OP_LDW) begin
      pc_nx = pc_q + 1'b1;
      case (aaf_pkg::op_e'(cmd_q))
        aaf_pkg::OP_LDA, aaf_pkg::OP_STA, aaf_pkg::OP_ADD, aaf_pkg::OP_SUB,
        aaf_pkg::OP_MUL, aaf_pkg::OP_DIV, aaf_pkg::OP_XOR, aaf_pkg::OP_OR,
        aaf_pkg::OP_AND: ar_nx = {{(aaf_pkg::PC_W - aaf_pkg::ADDR_W){1'b0}}, addr_q};
        aaf_pkg::OP_INC: ar_nx = aaf_pkg::AR_INC;
        aaf_pkg::OP_CMA: ar_nx = aaf_pkg::AR_CMA;
        aaf_pkg::OP_CLA: ar_nx = aaf_pkg::AR_CLA;
        aaf_pkg::OP_HLT: ar_nx = aaf_pkg::AR_HLT;
        default:         ar_nx = pc_q;
      endcase
      if (!err_q) begin
        flags_nx.parity = ~^pend_q;
        flags_nx.sign   = pend_q[W-1];
        flags_nx.zero   = !pend_q[W-1] && (pend_q == '0);
        flags_nx.carry  = carry;
        acc_nx          = pend_red;
      end
    end
    out_nx.acc_value       = $signed(acc_nx);
    out_nx.zero_flag       = flags_nx.zero;
    out_nx.sign_flag       = flags_nx.sign;
    out_nx.carry_flag      = flags_nx.carry;
    out_nx.parity_flag     = flags_nx.parity;
    out_nx.syntax_error    = err_q && (cmd_q != aaf_pkg::OP_LDW);
    out_nx.address_reg     = ar_nx;
    out_nx.program_counter = pc_nx;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q   <= in_data_i.cmd;
      addr_q  <= in_data_i.addr;
      idx_q   <= idx_in;
      wdata_q <= in_data_i.write_data;
    end
    if (cmd_i.exec) begin
      pend_q <= pend_d;
      err_q  <= err_d;
    end else if (cmd_i.div_take) begin
      pend_q <= div_quot;
    end
    if (cmd_i.commit) begin
      out_q <= out_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      flags_q     <= '0;
      pc_q        <= '0;
      ar_q        <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.commit) begin
        acc_q   <= acc_nx;
        flags_q <= flags_nx;
        ar_q    <= ar_nx;
      end
      // a start address write reloads the pc
      if (cfg_we_i) begin
        pc_q <= cfg_data_i;
      end else if (cmd_i.commit) begin
        pc_q <= pc_nx;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last   = (clr_cnt_q == IDX_W'(MEM_WORDS - 1));
  assign sts_o.div_needed = (cmd_q == aaf_pkg::OP_DIV) && (operand != '0);
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || out_ready_i))
    else $error("result committed over an unread word");

  a_pc_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (cmd_q != aaf_pkg::OP_LDW) && !cfg_we_i)
      |=> (pc_q == $past(pc_q) + 1'b1))
    else $error("pc did not advance on instruction");

  a_carry_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.carry_flag) |-> (out_q.acc_value[W-1:aaf_pkg::CARRY_BIT] == '0))
    else $error("carry set but accumulator not reduced");

  a_zero_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(flags_q.zero && flags_q.sign))
    else $error("zero and sign flags both set");
`endif

endmodule

[hdl/aaf_ctrl.sv]
// aaf_ctrl: sequencing state machine for clear, accept, execute, divide, commit
// depends on aaf_pkg
module aaf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  aaf_pkg::ctrl_sts_t sts_i,
  output aaf_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.div_needed) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/accumulator_alu_with_flags_core.sv]
// accumulator alu with flags: one instruction per accepted word, 32-bit accumulator
// result word registered at commit, after execute (and divide, for a nonzero divisor)
// next word accepted only after the previous one commits; divides use a 32-step loop
// reset: accumulator, flags, pc and ar clear; data memory is zeroed by a clearing
// pass over all MEM_WORDS words during which no word is accepted; config is always taken
// depends on aaf_pkg, aaf_ctrl, aaf_dp
module accumulator_alu_with_flags_core #(
  parameter int unsigned MEM_WORDS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // instruction words
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  aaf_pkg::in_t             in_data_i,
  // result words
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output aaf_pkg::out_t            out_data_o,
  // start address write, reloads the program counter
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [aaf_pkg::PC_W-1:0] cfg_data_i
);

  aaf_pkg::ctrl_cmd_t ctrl_cmd;
  aaf_pkg::ctrl_sts_t ctrl_sts;

  // the user must issue config writes only while idle; the block itself does not enforce this, and they never stall
  assign cfg_ready_o = 1'b1;

  // controller: clear pass, then accept -> execute -> (divide) -> commit
  aaf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (ctrl_sts),
    .cmd_o     (ctrl_cmd)
  );

  // datapath: memory, alu, divider, architectural registers and output word
  aaf_dp #(
    .MEM_WORDS(MEM_WORDS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ctrl_cmd),
    .sts_o      (ctrl_sts),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

endmodule
